### rtl/core/suspect_alarm_blocklist_unit_macros.svh
// ----------------------------------------------------------------------------
// suspect alarm blocklist assertion macros
// shared property wrappers, clocked on i_clk, quiet while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef SUSPECT_ALARM_BLOCKLIST_UNIT_MACROS_SVH
`define SUSPECT_ALARM_BLOCKLIST_UNIT_MACROS_SVH

// same-cycle implication
`define SAB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SAB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/sab_pkg.sv
// ----------------------------------------------------------------------------
// sab_pkg
// types and fixed widths shared by the suspect alarm blocklist unit
// ----------------------------------------------------------------------------
package sab_pkg;

    localparam int IN_ADDR_W = 16;
    localparam int NBR_W     = 8;
    localparam int ALARM_W   = 8;

    localparam logic [ALARM_W-1:0] ALARM_MAX = 8'hFF;
    localparam logic [ALARM_W-1:0] ALARM_ONE = 8'h01;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUS_START,
        ST_SUS_WAIT,
        ST_ALARM_UPD,
        ST_CLASSIFY,
        ST_BLK_WAIT,
        ST_OUT
    } t_state;

    // commands into a key table
    typedef struct packed {
        logic start;
        logic append;
    } t_scan_cmd;

    // status out of a key table
    typedef struct packed {
        logic done;
        logic hit;
        logic full;
    } t_scan_sts;

endpackage

### rtl/core/sab_key_scan.sv
// ----------------------------------------------------------------------------
// sab_key_scan
// append-only key memory with a fill count and a pipelined linear search
// ----------------------------------------------------------------------------
module sab_key_scan #(
    parameter int DEPTH = 64,
    parameter int KEY_W = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  sab_pkg::t_scan_cmd         i_cmd,
    input  logic [KEY_W-1:0]           i_key,
    output sab_pkg::t_scan_sts         o_sts,
    output logic [$clog2(DEPTH)-1:0]   o_slot
);
    import sab_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [KEY_W-1:0] r_mem [DEPTH];
    logic [CNT_W-1:0] r_fill;
    logic             r_busy;
    logic [CNT_W-1:0] r_rd_idx;
    logic             r_chk_vld;
    logic [IDX_W-1:0] r_chk_idx;
    logic [KEY_W-1:0] r_rd_key;

    logic w_full;
    logic w_rd_go;
    logic w_hit;
    logic w_miss;

    assign w_full  = (r_fill == CNT_W'(DEPTH));
    assign w_rd_go = r_busy && (r_rd_idx < r_fill);
    assign w_hit   = r_busy && r_chk_vld && (r_rd_key == i_key);
    assign w_miss  = r_busy && !r_chk_vld && !w_rd_go;

    assign o_sts.done = w_hit || w_miss;
    assign o_sts.hit  = w_hit;
    assign o_sts.full = w_full;
    // hit slot, or the next free slot on a miss
    assign o_slot     = w_hit ? r_chk_idx : r_fill[IDX_W-1:0];

    // memory port and read pipeline payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.append && !w_full) begin
            r_mem[r_fill[IDX_W-1:0]] <= i_key;
        end
        if (w_rd_go) begin
            r_rd_key  <= r_mem[r_rd_idx[IDX_W-1:0]];
            r_chk_idx <= r_rd_idx[IDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_busy    <= 1'b0;
            r_rd_idx  <= '0;
            r_chk_vld <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_busy    <= 1'b1;
                r_rd_idx  <= '0;
                r_chk_vld <= 1'b0;
            end else if (o_sts.done) begin
                r_busy    <= 1'b0;
                r_chk_vld <= 1'b0;
            end else if (r_busy) begin
                r_chk_vld <= w_rd_go;
                if (w_rd_go) begin
                    r_rd_idx <= r_rd_idx + CNT_W'(1);
                end
            end
            if (i_cmd.append && !w_full) begin
                r_fill <= r_fill + CNT_W'(1);
            end
        end
    end

endmodule

### rtl/core/suspect_alarm_blocklist_unit.sv
// ----------------------------------------------------------------------------
// suspect_alarm_blocklist_unit
// alarm counting per suspect node and blocklisting of classified attackers
// ----------------------------------------------------------------------------
// Each input beat reports one alarm against a suspect address, with that
// node's neighbour count, and yields exactly one output beat. The suspect
// table is searched one entry per cycle through its memory read port, and
// the blocklist is searched the same way when an item is classified as
// attacker. The result of an item waits in its state for the output
// register, and holds the sequencer there while the output beat is
// stalled. Only one item is in work at a time; a finished result sits in the
// output register while the next beat is taken. Both tables start empty after
// reset, with no clearing pass. Only the low ADDR_BITS bits of the address are
// compared. A node counts as attacker when neighbours are nonzero and twice
// its alarm count reaches the neighbour count; alarm counts saturate at 255.
// ----------------------------------------------------------------------------
`include "suspect_alarm_blocklist_unit_macros.svh"

module suspect_alarm_blocklist_unit #(
    parameter int SUSPECT_DEPTH = 64,
    parameter int BLOCK_DEPTH   = 32,
    parameter int ADDR_BITS     = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [sab_pkg::IN_ADDR_W-1:0] i_suspect_address,
    input  logic [sab_pkg::NBR_W-1:0]     i_neighbor_count,
    // output channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [sab_pkg::ALARM_W-1:0]   o_alarm_count,
    output logic                          o_is_new_suspect,
    output logic                          o_suspect_table_full,
    output logic                          o_classified_attacker,
    output logic                          o_newly_blocked,
    output logic                          o_was_blocked,
    output logic                          o_blocklist_full
);
    import sab_pkg::*;

    // compared address width, never more than the port carries
    localparam int KEY_W     = (ADDR_BITS < IN_ADDR_W) ? ADDR_BITS : IN_ADDR_W;
    localparam int SUS_IDX_W = $clog2(SUSPECT_DEPTH);

    // sequencer
    t_state r_state, n_state;

    // item in work
    logic [KEY_W-1:0]     r_key;
    logic [NBR_W-1:0]     r_nbr;
    logic [SUS_IDX_W-1:0] r_slot;
    logic [ALARM_W-1:0]   r_alarms;
    logic                 r_is_new;
    logic                 r_sus_full;
    logic                 r_attacker;
    logic                 r_new_blk;
    logic                 r_was_blk;
    logic                 r_blk_full;

    // output register
    logic                 r_out_vld;
    logic [ALARM_W-1:0]   r_o_alarms;
    logic                 r_o_is_new;
    logic                 r_o_sus_full;
    logic                 r_o_attacker;
    logic                 r_o_new_blk;
    logic                 r_o_was_blk;
    logic                 r_o_blk_full;

    // alarm count memory, indexed like the suspect key table
    logic [ALARM_W-1:0]   r_alarm_mem [SUSPECT_DEPTH];
    logic [ALARM_W-1:0]   r_alarm_q;
    logic                 w_alm_we;
    logic [SUS_IDX_W-1:0] w_alm_waddr;
    logic [ALARM_W-1:0]   w_alm_wdata;
    logic [ALARM_W-1:0]   w_alarm_inc;

    // key tables
    t_scan_cmd            w_sus_cmd, w_blk_cmd;
    t_scan_sts            w_sus_sts, w_blk_sts;
    logic [SUS_IDX_W-1:0] w_sus_slot;

    logic                 w_in_acc;
    logic                 w_out_load;
    logic                 w_attack;

    assign o_stall    = (r_state != ST_IDLE);
    assign w_in_acc   = i_valid && !o_stall;
    assign w_out_load = (r_state == ST_OUT) && (!r_out_vld || !i_stall);

    // saturating alarm increment
    assign w_alarm_inc = (r_alarm_q == ALARM_MAX) ? ALARM_MAX : r_alarm_q + ALARM_ONE;

    // attacker when 2 * alarms >= neighbours, neighbours nonzero
    assign w_attack = (r_nbr != '0) && ({r_alarms, 1'b0} >= {1'b0, r_nbr});

    sab_key_scan #(
        .DEPTH (SUSPECT_DEPTH),
        .KEY_W (KEY_W)
    ) u_sus_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_sus_cmd),
        .i_key   (r_key),
        .o_sts   (w_sus_sts),
        .o_slot  (w_sus_slot)
    );

    // blocklist slot number is of no interest, only hit or miss
    sab_key_scan #(
        .DEPTH (BLOCK_DEPTH),
        .KEY_W (KEY_W)
    ) u_blk_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_blk_cmd),
        .i_key   (r_key),
        .o_sts   (w_blk_sts),
        .o_slot  ()
    );

    // alarm memory: read every cycle at the slot the search reports,
    // so the count of a hit entry is registered and ready in the cycle after the hit
    always_ff @(posedge i_clk) begin
        if (w_alm_we) begin
            r_alarm_mem[w_alm_waddr] <= w_alm_wdata;
        end
        r_alarm_q <= r_alarm_mem[w_sus_slot];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state, table commands and alarm write-back
    always_comb begin
        n_state     = r_state;
        w_sus_cmd   = '0;
        w_blk_cmd   = '0;
        w_alm_we    = 1'b0;
        w_alm_waddr = r_slot;
        w_alm_wdata = w_alarm_inc;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = ST_SUS_START;
                end
            end
            ST_SUS_START: begin
                w_sus_cmd.start = 1'b1;
                n_state         = ST_SUS_WAIT;
            end
            ST_SUS_WAIT: begin
                if (w_sus_sts.done) begin
                    if (w_sus_sts.hit) begin
                        n_state = ST_ALARM_UPD;
                    end else begin
                        // new suspect takes the next free slot with one alarm
                        if (!w_sus_sts.full) begin
                            w_sus_cmd.append = 1'b1;
                            w_alm_we         = 1'b1;
                            w_alm_waddr      = w_sus_slot;
                            w_alm_wdata      = ALARM_ONE;
                        end
                        n_state = ST_CLASSIFY;
                    end
                end
            end
            ST_ALARM_UPD: begin
                w_alm_we = 1'b1;
                n_state  = ST_CLASSIFY;
            end
            ST_CLASSIFY: begin
                if (w_attack) begin
                    w_blk_cmd.start = 1'b1;
                    n_state         = ST_BLK_WAIT;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_BLK_WAIT: begin
                if (w_blk_sts.done) begin
                    if (!w_blk_sts.hit && !w_blk_sts.full) begin
                        w_blk_cmd.append = 1'b1;
                    end
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // item payload and result flags
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_key      <= i_suspect_address[KEY_W-1:0];
            r_nbr      <= i_neighbor_count;
            r_alarms   <= '0;
            r_is_new   <= 1'b0;
            r_sus_full <= 1'b0;
            r_attacker <= 1'b0;
            r_new_blk  <= 1'b0;
            r_was_blk  <= 1'b0;
            r_blk_full <= 1'b0;
        end
        if (r_state == ST_SUS_WAIT && w_sus_sts.done) begin
            r_slot <= w_sus_slot;
            if (!w_sus_sts.hit) begin
                if (w_sus_sts.full) begin
                    r_sus_full <= 1'b1;
                end else begin
                    r_alarms <= ALARM_ONE;
                    r_is_new <= 1'b1;
                end
            end
        end
        if (r_state == ST_ALARM_UPD) begin
            r_alarms <= w_alarm_inc;
        end
        if (r_state == ST_CLASSIFY) begin
            r_attacker <= w_attack;
        end
        if (r_state == ST_BLK_WAIT && w_blk_sts.done) begin
            r_was_blk  <= w_blk_sts.hit;
            r_new_blk  <= !w_blk_sts.hit && !w_blk_sts.full;
            r_blk_full <= !w_blk_sts.hit && w_blk_sts.full;
        end
        if (w_out_load) begin
            r_o_alarms   <= r_alarms;
            r_o_is_new   <= r_is_new;
            r_o_sus_full <= r_sus_full;
            r_o_attacker <= r_attacker;
            r_o_new_blk  <= r_new_blk;
            r_o_was_blk  <= r_was_blk;
            r_o_blk_full <= r_blk_full;
        end
    end

    // output beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_load) begin
            r_out_vld <= 1'b1;
        end else if (r_out_vld && !i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    assign o_valid               = r_out_vld;
    assign o_alarm_count         = r_o_alarms;
    assign o_is_new_suspect      = r_o_is_new;
    assign o_suspect_table_full  = r_o_sus_full;
    assign o_classified_attacker = r_o_attacker;
    assign o_newly_blocked       = r_o_new_blk;
    assign o_was_blocked         = r_o_was_blk;
    assign o_blocklist_full      = r_o_blk_full;

    // blocklist outcome is exclusive and only for attackers
    `SAB_ASSERT_NOW(a_blk_onehot, o_valid,
        $onehot0({o_newly_blocked, o_was_blocked, o_blocklist_full}),
        "blocklist outcome flags not exclusive")
    `SAB_ASSERT_NOW(a_blk_needs_attacker,
        o_valid && (o_newly_blocked || o_was_blocked || o_blocklist_full),
        o_classified_attacker, "blocklist outcome without attacker")
    // a rejected suspect has no alarms and cannot be an attacker
    `SAB_ASSERT_NOW(a_sus_full_quiet, o_valid && o_suspect_table_full,
        (o_alarm_count == '0) && !o_is_new_suspect && !o_classified_attacker,
        "full suspect table with alarms or attacker")
    // starting the suspect search is always followed by the suspect wait state
    `SAB_ASSERT_NEXT(a_sus_start_busy, r_state == ST_SUS_START,
        r_state == ST_SUS_WAIT, "suspect search not entered")

endmodule
